[src/assert_macros.svh]
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on the rising clock edge, ignored while reset is high.
`define BSVE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Trigger in one cycle, condition in the next.
`define BSVE_ASSERT_NEXT(label, trig, cond, msg) \
   `BSVE_ASSERT(label, (trig) |=> (cond), msg)

`endif

[src/bsve_pkg.sv]
// Package of the blend skinning vertex engine: widths, codes and helpers.
`timescale 1ns / 1ps

package bsve_pkg;

   // fixed point format and destination store size (a power of two)
   localparam int FRAC_BITS   = 16;
   localparam int WEIGHT_BITS = 16;
   localparam int DEST_DEPTH  = 4096;
   localparam int ADDR_BITS   = $clog2(DEST_DEPTH);

   // datapath widths
   localparam int PROD_W  = 64;
   localparam int ACC_W   = PROD_W - FRAC_BITS + 2;
   localparam int WPROD_W = 50;

   // stream word widths
   localparam int REQ_DATA_W = 128;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 112;

   // opcodes
   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_RIGID = 2'd1;
   localparam logic [1:0] OP_FIRST = 2'd2;
   localparam logic [1:0] OP_ADD   = 2'd3;

   typedef logic signed [31:0] word_type;

   // saturate a 64-bit signed value to 32 signed bits
   function automatic word_type sat_word(input logic signed [63:0] v);
      word_type r;
      if (v[63:31] == '0 || v[63:31] == '1) begin
         r = v[31:0];
      end else if (v[63]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7fff_ffff;
      end
      return r;
   endfunction

endpackage

[src/blend_skinning_vertex_engine.sv]
// Top level of the blend skinning vertex engine.
//
//   channel  dir  fields                                    handshake
//   req      in   tuser: opcode, row_select                 req_tvalid / req_tready
//                 tdata: val_x, val_y, val_z, blend_weight,
//                        dest_index
//   rsp      out  tdata: out_index, out_x, out_y, out_z     rsp_tvalid / rsp_tready
//
// A load word leaves the input open; the next word can be taken in the cycle after it.
// A vertex word closes the input until its result is written back; one shared 32x32
// multiplier forms the nine matrix products, one 32x18 multiplier the weights.
// The destination vectors sit in one 96-bit RAM, read at acceptance and written back
// in the last cycle; one vertex is in flight, so accesses never overlap.
// The result register frees the input side; a stalled result only holds the last step.
// Synchronous reset clears the bone matrix and the control state; the RAM is not cleared.
`timescale 1ns / 1ps

module blend_skinning_vertex_engine (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [31:0] val_x, [63:32] val_y, [95:64] val_z, [112:96] blend_weight,
   // [124:113] dest_index, [127:125] zero
   input  logic [bsve_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [1:0] opcode, [3:2] row_select
   input  logic [bsve_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [11:0] out_index, [43:12] out_x, [75:44] out_y, [107:76] out_z, [111:108] zero
   output logic [bsve_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   import bsve_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MUL   = 2'd1;
   localparam logic [1:0] ST_WEIGH = 2'd2;
   localparam logic [1:0] ST_WRITE = 2'd3;

   // request fields
   logic [1:0]           req_op;
   logic [1:0]           req_row;
   word_type             req_x, req_y, req_z;
   logic [16:0]          req_w;
   logic [11:0]          req_dest;
   logic [31:0]          dest_wide;
   logic [ADDR_BITS-1:0] req_addr;
   logic [3:0]           load_base;

   // control registers
   logic [1:0]           state_ff, state_in;
   word_type             mat_ff [12];
   word_type             mat_in [12];
   logic                 prod_vld_ff, prod_vld_in;
   logic                 wvld_ff, wvld_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [1:0]           op_ff, op_in;
   logic [16:0]          w_ff, w_in;
   logic [ADDR_BITS-1:0] idx_ff, idx_in;
   word_type             opnd_ff [3];
   word_type             opnd_in [3];
   logic [1:0]           row_ff, row_in, col_ff, col_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [1:0]           prod_row_ff, prod_row_in, prod_col_ff, prod_col_in;
   logic signed [ACC_W-1:0] acc_ff [3];
   logic signed [ACC_W-1:0] acc_in [3];
   logic [1:0]           wstep_ff, wstep_in;
   logic signed [WPROD_W-1:0] wprod_ff, wprod_in;
   word_type             satacc_ff, satacc_in;
   logic [1:0]           wcol_ff, wcol_in;
   word_type             v_ff [3];
   word_type             v_in [3];
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // datapath wires
   logic [3:0]           mat_idx, tr_idx;
   word_type             opnd_sel, coef_sel;
   logic signed [ACC_W-1:0] term, trans, acc_sel;
   word_type             nv [3];
   word_type             rd_vec [3];
   logic [31:0]          idx_wide;
   logic                 out_free;

   // RAM port
   logic                 ram_wr_en, ram_rd_en;
   logic [95:0]          ram_wr_data, ram_rd_data;

   // unpack the request word
   assign req_op    = req_tuser[1:0];
   assign req_row   = req_tuser[3:2];
   assign req_x     = req_tdata[31:0];
   assign req_y     = req_tdata[63:32];
   assign req_z     = req_tdata[95:64];
   assign req_w     = req_tdata[112:96];
   assign req_dest  = req_tdata[124:113];
   assign dest_wide = 32'(req_dest);
   assign req_addr  = dest_wide[ADDR_BITS-1:0];
   assign load_base = {1'b0, req_row, 1'b0} + {2'b00, req_row};

   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // matrix element for the product being issued: row-major row*3 + col
   assign mat_idx  = {1'b0, row_ff, 1'b0} + {2'b00, row_ff} + {2'b00, col_ff};
   assign coef_sel = mat_ff[mat_idx];
   assign tr_idx   = 4'd9 + {2'b00, prod_col_ff};

   always_comb begin
      unique case (row_ff)
         2'd1:    opnd_sel = opnd_ff[1];
         2'd2:    opnd_sel = opnd_ff[2];
         default: opnd_sel = opnd_ff[0];
      endcase
   end

   always_comb begin
      unique case (wstep_ff)
         2'd1:    acc_sel = acc_ff[1];
         2'd2:    acc_sel = acc_ff[2];
         default: acc_sel = acc_ff[0];
      endcase
   end

   // floor-shifted product and translation, both at accumulator width
   assign term  = ACC_W'(prod_ff >>> FRAC_BITS);
   assign trans = ACC_W'(mat_ff[tr_idx]);

   // stored vector and the write-back value
   assign rd_vec[0] = ram_rd_data[31:0];
   assign rd_vec[1] = ram_rd_data[63:32];
   assign rd_vec[2] = ram_rd_data[95:64];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (op_ff == OP_ADD) begin
            nv[c] = sat_word(64'(v_ff[c]) + 64'(rd_vec[c]));
         end else begin
            nv[c] = v_ff[c];
         end
      end
   end

   assign ram_wr_data = {nv[2], nv[1], nv[0]};
   assign idx_wide    = 32'(idx_ff);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      mat_in       = mat_ff;
      prod_vld_in  = 1'b0;
      wvld_in      = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      op_in        = op_ff;
      w_in         = w_ff;
      idx_in       = idx_ff;
      opnd_in      = opnd_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      prod_in      = prod_ff;
      prod_row_in  = prod_row_ff;
      prod_col_in  = prod_col_ff;
      acc_in       = acc_ff;
      wstep_in     = wstep_ff;
      wprod_in     = wprod_ff;
      satacc_in    = satacc_ff;
      wcol_in      = wcol_ff;
      v_in         = v_ff;
      rsp_data_in  = rsp_data_ff;
      ram_rd_en    = 1'b0;
      ram_wr_en    = 1'b0;

      // result register drains independently
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_op == OP_LOAD) begin
                  mat_in[load_base]        = req_x;
                  mat_in[load_base + 4'd1] = req_y;
                  mat_in[load_base + 4'd2] = req_z;
               end else begin
                  op_in      = req_op;
                  w_in       = req_w;
                  idx_in     = req_addr;
                  opnd_in[0] = req_x;
                  opnd_in[1] = req_y;
                  opnd_in[2] = req_z;
                  row_in     = 2'd0;
                  col_in     = 2'd0;
                  ram_rd_en  = 1'b1;
                  state_in   = ST_MUL;
               end
            end
         end

         ST_MUL: begin
            // issue one product per cycle, rows inner, columns outer
            if (col_ff != 2'd3) begin
               prod_in     = PROD_W'(opnd_sel) * PROD_W'(coef_sel);
               prod_vld_in = 1'b1;
               prod_row_in = row_ff;
               prod_col_in = col_ff;
               if (row_ff == 2'd2) begin
                  row_in = 2'd0;
                  col_in = col_ff + 2'd1;
               end else begin
                  row_in = row_ff + 2'd1;
               end
            end
            // accumulate the product issued last cycle
            if (prod_vld_ff) begin
               if (prod_row_ff == 2'd0) begin
                  acc_in[prod_col_ff] = trans + term;
               end else begin
                  acc_in[prod_col_ff] = acc_ff[prod_col_ff] + term;
               end
            end else if (col_ff == 2'd3) begin
               wstep_in = 2'd0;
               state_in = ST_WEIGH;
            end
         end

         ST_WEIGH: begin
            // saturate and weigh one column per cycle
            if (wstep_ff != 2'd3) begin
               satacc_in = sat_word(64'(acc_sel));
               wprod_in  = WPROD_W'(sat_word(64'(acc_sel))) *
                           WPROD_W'($signed({1'b0, w_ff}));
               wcol_in   = wstep_ff;
               wvld_in   = 1'b1;
               wstep_in  = wstep_ff + 2'd1;
            end else begin
               state_in = ST_WRITE;
            end
            if (wvld_ff) begin
               if (op_ff == OP_RIGID) begin
                  v_in[wcol_ff] = satacc_ff;
               end else begin
                  v_in[wcol_ff] = sat_word(64'(wprod_ff >>> WEIGHT_BITS));
               end
            end
         end

         ST_WRITE: begin
            // write back and present the result once the output is free
            if (out_free) begin
               ram_wr_en    = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0000, nv[2], nv[1], nv[0], idx_wide[11:0]};
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prod_vld_ff  <= 1'b0;
         wvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 12; i++) begin
            mat_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         prod_vld_ff  <= prod_vld_in;
         wvld_ff      <= wvld_in;
         rsp_valid_ff <= rsp_valid_in;
         mat_ff       <= mat_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      w_ff        <= w_in;
      idx_ff      <= idx_in;
      opnd_ff     <= opnd_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      prod_ff     <= prod_in;
      prod_row_ff <= prod_row_in;
      prod_col_ff <= prod_col_in;
      acc_ff      <= acc_in;
      wstep_ff    <= wstep_in;
      wprod_ff    <= wprod_in;
      satacc_ff   <= satacc_in;
      wcol_ff     <= wcol_in;
      v_ff        <= v_in;
      rsp_data_ff <= rsp_data_in;
   end

   // destination vector store, x in the low word
   bsve_ram #(
      .WIDTH (96),
      .DEPTH (DEST_DEPTH)
   ) u_dest_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (req_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[src/bsve_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module bsve_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/bsve_checker.sv]
// Port-level checker of the blend skinning vertex engine and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bsve_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [bsve_pkg::REQ_USER_W-1:0] req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bsve_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import bsve_pkg::*;

   logic req_word, load_word, vertex_word;

   assign req_word    = req_tvalid && req_tready;
   assign load_word   = req_word && (req_tuser[1:0] == OP_LOAD);
   assign vertex_word = req_word && (req_tuser[1:0] != OP_LOAD);

   // a stalled result holds its word
   `BSVE_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp word changed under stall")

   // a vertex occupies the engine, so the input closes after it
   `BSVE_ASSERT_NEXT(a_vertex_busy, vertex_word, !req_tready, "input open right after a vertex")

   // a matrix load leaves the input open in the cycle after it
   `BSVE_ASSERT_NEXT(a_load_quick, load_word, req_tready, "input closed after a matrix load")

   // with no result pending, none can appear in the cycle after a vertex is accepted
   `BSVE_ASSERT_NEXT(a_no_early_rsp, vertex_word && !rsp_tvalid, !rsp_tvalid, "result too early")

   // padding bits of the result word stay zero
   `BSVE_ASSERT(a_rsp_pad, rsp_tvalid |-> (rsp_tdata[RSP_DATA_W-1:108] == '0), "rsp padding not zero")

endmodule

bind blend_skinning_vertex_engine bsve_checker u_bsve_checker (.*);
